### src/selective_repeat_frame_receiver_defines.svh
// assertion macros used by the checker file of the frame receiver
`ifndef SELECTIVE_REPEAT_FRAME_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_FRAME_RECEIVER_DEFINES_SVH

// property checked at every rising edge, skipped while reset is high
`define SRFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define SRFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/srfr_pkg.sv
// shared constants of the selective repeat frame receiver
`timescale 1ns / 1ps
package srfr_pkg;
  localparam int SEQ_BITS       = 16;
  localparam int SEQ_CNT_W      = $clog2(SEQ_BITS);
  localparam int CFG_W          = 7;
  localparam int DEF_MAX_WINDOW = 64;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd4;
  localparam logic [7:0] ESCAPE_BYTE = 8'h2F;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
endpackage

### src/selective_repeat_frame_receiver.sv
// selective repeat frame receiver top level
`timescale 1ns / 1ps
// Usage
//   s_axis: one stuffed frame byte per transfer. tdata = data_byte [7:0],
//   frame_seq [23:8], frame_check [31:24]; tuser = frame_start, tlast = frame_end.
//   m_axis: at most one reply per frame end. tdata = reply_seq [15:0],
//   tuser = reply_is_nack. cfg_wen / cfg_wdata write the window size (reset 4).
// Flow
//   payload, start and flag bytes: taken back to back.
//   frame end: a failed check loads a NACK; a frame outside the window is
//   dropped; otherwise the one-bit-a-step remainder unit (seq mod window)
//   runs, then an out-of-order frame does a slot memory read-modify-write
//   and an in-order one slides the expected number over marked slots (up to
//   MAX_WINDOW slots), then the reply register is loaded (none for a
//   duplicate).
// Reset
//   after rst the slot memory is swept clear, one entry a cycle, s_axis_tready
//   low until all MAX_WINDOW entries are clear; config writes are taken meanwhile.
// Stall
//   a reply waits in the output register while m_axis_tready is low; bytes keep
//   flowing until a frame end that makes a reply, which then holds the input
//   until the waiting reply is gone.
module selective_repeat_frame_receiver
  import srfr_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,      // window_size
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte, frame_seq, frame_check
  input  logic                  s_axis_tuser,   // frame_start
  input  logic                  s_axis_tlast,   // frame_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // reply_seq
  output logic                  m_axis_tuser    // reply_is_nack
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (WIN_W > CFG_W) ? WIN_W : CFG_W;

  // controller states
  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_DIV       = 4'd2;
  localparam logic [3:0] ST_ROUTE     = 4'd3;
  localparam logic [3:0] ST_LOOKUP    = 4'd4;
  localparam logic [3:0] ST_MARK      = 4'd5;
  localparam logic [3:0] ST_SLIDE_RD  = 4'd6;
  localparam logic [3:0] ST_SLIDE_CHK = 4'd7;
  localparam logic [3:0] ST_REPLY     = 4'd8;

  logic [3:0]          state;
  logic [CFG_W-1:0]    window_size;
  logic [SEQ_BITS-1:0] expected_seq;
  logic [7:0]          running_check;
  logic                escape_pending;

  // frame under work
  logic [SEQ_BITS-1:0] seq_r;
  logic                pend_nack;
  logic                in_order;

  // remainder unit
  logic [SEQ_BITS-1:0]  div_shift;
  logic [WIN_W-1:0]     rem;
  logic [SEQ_CNT_W-1:0] bit_cnt;

  // slot walk and memory sweep
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slide_cnt;
  logic [SLOT_W-1:0] clr_cnt;

  // slot-full memory
  logic              slot_mem [MAX_WINDOW];
  logic [SLOT_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_wdata;
  logic              mem_rdata;

  // input fields
  logic [7:0]          in_byte;
  logic [SEQ_BITS-1:0] in_seq;
  logic [7:0]          in_check;
  assign in_byte  = s_axis_tdata[7:0];
  assign in_seq   = s_axis_tdata[23:8];
  assign in_check = s_axis_tdata[31:24];

  logic in_xfer;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // active window: 0 acts as 1, above the memory depth clamps to it
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] win_c;
  logic [WIN_W-1:0] win;
  always_comb begin
    cfg_ext = CMP_W'(window_size);
    if (cfg_ext == '0) begin
      win_c = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
      win_c = CMP_W'(MAX_WINDOW);
    end else begin
      win_c = cfg_ext;
    end
    win = WIN_W'(win_c);
  end

  // check at the closing flag; start on the same byte clears state first
  logic [7:0]          chk_base;
  logic                esc_base;
  logic [7:0]          chk_final;
  logic                chk_bad;
  logic [SEQ_BITS-1:0] seq_gap;
  logic                in_window;
  always_comb begin
    chk_base  = s_axis_tuser ? 8'd0 : running_check;
    esc_base  = s_axis_tuser ? 1'b0 : escape_pending;
    chk_final = esc_base ? (chk_base ^ in_byte) : chk_base;
    chk_bad   = (chk_final != in_check);
    seq_gap   = in_seq - expected_seq;
    in_window = (seq_gap < SEQ_BITS'(win));
  end

  // restoring remainder step, one sequence bit a cycle
  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   rem_sub;
  logic [WIN_W-1:0] rem_new;
  always_comb begin
    rem_sh  = {rem, div_shift[SEQ_BITS-1]};
    rem_sub = rem_sh - {1'b0, win};
    rem_new = (rem_sh >= {1'b0, win}) ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
  end

  // slot of expected_seq + 1, tracked from the slot of expected_seq
  logic [SEQ_BITS-1:0] exp_inc;
  logic [SLOT_W-1:0]   base_slot;
  logic [WIN_W-1:0]    slot_p1;
  logic [SLOT_W-1:0]   adv_slot;
  always_comb begin
    exp_inc   = expected_seq + 1'b1;
    base_slot = (state == ST_ROUTE) ? rem[SLOT_W-1:0] : slot;
    slot_p1   = WIN_W'(base_slot) + 1'b1;
    // the sequence wrap restarts the slot count at zero
    if (slot_p1 == win || exp_inc == '0) begin
      adv_slot = '0;
    end else begin
      adv_slot = slot_p1[SLOT_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    mem_addr  = slot;
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_addr = clr_cnt;
        mem_we   = 1'b1;
      end
      ST_SLIDE_CHK: begin
        mem_we = mem_rdata;          // clear a full slot as the window slides
      end
      ST_MARK: begin
        mem_we    = !mem_rdata;      // mark a free slot
        mem_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= slot_mem[mem_addr];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  // main controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      expected_seq   <= '0;
      running_check  <= '0;
      escape_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLOT_W'(MAX_WINDOW - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (!s_axis_tlast) begin
              // payload unstuffing
              if (s_axis_tuser) begin
                running_check  <= '0;
                escape_pending <= 1'b0;
              end else if (escape_pending) begin
                running_check  <= running_check ^ in_byte;
                escape_pending <= 1'b0;
              end else if (in_byte == ESCAPE_BYTE) begin
                escape_pending <= 1'b1;
              end else begin
                running_check <= running_check ^ in_byte;
              end
            end else begin
              running_check  <= '0;
              escape_pending <= 1'b0;
              seq_r          <= in_seq;
              if (chk_bad) begin
                pend_nack <= 1'b1;
                state     <= ST_REPLY;
              end else if (in_window) begin
                pend_nack <= 1'b0;
                in_order  <= (seq_gap == '0);
                div_shift <= in_seq;
                rem       <= '0;
                bit_cnt   <= '0;
                state     <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          rem       <= rem_new;
          div_shift <= {div_shift[SEQ_BITS-2:0], 1'b0};
          bit_cnt   <= bit_cnt + 1'b1;
          if (bit_cnt == SEQ_CNT_W'(SEQ_BITS - 1)) begin
            state <= ST_ROUTE;
          end
        end
        ST_ROUTE: begin
          if (in_order) begin
            expected_seq <= exp_inc;
            slot         <= adv_slot;
            slide_cnt    <= '0;
            state        <= ST_SLIDE_RD;
          end else begin
            slot  <= rem[SLOT_W-1:0];
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_MARK;
        end
        ST_MARK: begin
          // an already marked slot is a duplicate: no reply
          state <= mem_rdata ? ST_IDLE : ST_REPLY;
        end
        ST_SLIDE_RD: begin
          state <= ST_SLIDE_CHK;
        end
        ST_SLIDE_CHK: begin
          if (!mem_rdata) begin
            state <= ST_REPLY;
          end else begin
            expected_seq <= exp_inc;
            slot         <= adv_slot;
            slide_cnt    <= slide_cnt + 1'b1;
            state <= (slide_cnt == SLOT_W'(MAX_WINDOW - 1)) ? ST_REPLY : ST_SLIDE_RD;
          end
        end
        ST_REPLY: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_REPLY && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPLY && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= pend_nack ? seq_r : seq_r + 1'b1;
      m_axis_tuser <= pend_nack;
    end
  end

endmodule

### src/srfr_checker.sv
// port-level checks of the selective repeat frame receiver, bound to the top level
`timescale 1ns / 1ps
`include "selective_repeat_frame_receiver_defines.svh"
module srfr_checker
  import srfr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wen,
  input logic [CFG_W-1:0]      cfg_wdata,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // a stalled reply keeps its contents
  `SRFR_ASSERT(a_reply_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "reply changed while stalled")

  // reset starts the memory sweep with no reply pending
  `SRFR_ASSERT_ALWAYS(a_reset_sweep, rst |=> !s_axis_tready && !m_axis_tvalid, "input open or reply pending right after reset")

  // payload bytes never stop the byte stream
  `SRFR_ASSERT(a_payload_flow, s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready, "input closed after a payload byte")

endmodule

bind selective_repeat_frame_receiver srfr_checker u_srfr_checker (.*);

### bench/tb.sv
// self-checking bench for the selective repeat frame receiver: stuffed frames in, ack/nack out
`timescale 1ns / 1ps
module tb;
  import srfr_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 200;   // longest frame end: remainder, then a full slide
  localparam int HOLD_AFTER  = 200;   // link bytes in before the long reply hold starts
  localparam int LONG_HOLD   = 600;
  localparam int SLOT_IDX_W  = $clog2(DEF_MAX_WINDOW);

  // one byte on the link, with the side fields that travel with it
  typedef struct packed {
    logic [7:0]          check;
    logic [SEQ_BITS-1:0] seq;
    logic                frame_end;
    logic                frame_start;
    logic [7:0]          data;
  } link_byte_t;

  typedef struct packed {
    logic                nack;
    logic [SEQ_BITS-1:0] seq;
  } reply_t;

  // receiver state: next in-order number, slot-full marks, unstuffing state, window register
  typedef struct packed {
    logic [SEQ_BITS-1:0]       next_seq;
    logic [DEF_MAX_WINDOW-1:0] slot_mark;
    logic [7:0]                xor_acc;
    logic                      esc_pending;
    logic [CFG_W-1:0]          window;
  } arq_state_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // data_byte, frame_seq, frame_check
  logic                  s_axis_tuser = 1'b0; // frame_start
  logic                  s_axis_tlast = 1'b0; // frame_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // reply_seq
  logic                  m_axis_tuser;        // reply_is_nack

  selective_repeat_frame_receiver DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial forever #6 clk = ~clk;

  arq_state_t rx_model;   // follows the block, advanced on accepted transfers
  arq_state_t gen_state;  // follows the stream as it is generated, steers sequence choice
  link_byte_t link_bytes[$];
  reply_t     pending_replies[$];
  link_byte_t on_wire;
  link_byte_t next_byte;
  reply_t     drv_reply;
  reply_t     want;
  int         send_gap = 0;
  int         recv_wait = 0;
  bit         send_throttle = 1'b1;
  bit         recv_throttle = 1'b1;
  bit         long_hold_done = 1'b0;
  int         quiet_cycles = 0;
  int         n_bytes_in = 0;
  int         n_acks = 0;
  int         n_nacks = 0;
  int         n_errors = 0;
  int         phase_items;
  logic [CFG_W-1:0] rand_win_a, rand_win_b;

  function automatic int unsigned active_window(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
    return 32'(w);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [SEQ_BITS-1:0] rnd_seq();
    return SEQ_BITS'($urandom);
  endfunction

  // advances the receiver state by one link byte; returns 1 when a reply goes out
  function automatic bit arq_reply_step(inout arq_state_t st, input link_byte_t b,
                                        output reply_t r);
    int unsigned           win;
    int unsigned           k;
    logic [SEQ_BITS-1:0]   seq_gap;
    logic [SLOT_IDX_W-1:0] sidx;
    bit                    has_reply;
    has_reply = 1'b0;
    r = '0;
    win = active_window(st.window);
    if (b.frame_start) begin
      st.xor_acc = '0;
      st.esc_pending = 1'b0;
    end
    if (!b.frame_end) begin
      if (!b.frame_start) begin
        if (st.esc_pending) begin
          st.xor_acc ^= b.data;
          st.esc_pending = 1'b0;
        end else if (b.data == ESCAPE_BYTE) begin
          st.esc_pending = 1'b1;
        end else begin
          st.xor_acc ^= b.data;
        end
      end
    end else begin
      // an escaped closing byte is payload
      if (st.esc_pending) st.xor_acc ^= b.data;
      st.esc_pending = 1'b0;
      if (st.xor_acc != b.check) begin
        has_reply = 1'b1;
        r.nack = 1'b1;
        r.seq = b.seq;
      end else begin
        seq_gap = b.seq - st.next_seq;
        if (seq_gap == 0) begin
          // in order: step past it, then slide over slots already held
          st.next_seq = st.next_seq + 1'b1;
          k = 0;
          sidx = SLOT_IDX_W'(st.next_seq % win);
          while (k < DEF_MAX_WINDOW && st.slot_mark[sidx]) begin
            st.slot_mark[sidx] = 1'b0;
            st.next_seq = st.next_seq + 1'b1;
            sidx = SLOT_IDX_W'(st.next_seq % win);
            k++;
          end
          has_reply = 1'b1;
        end else if (seq_gap < win) begin
          sidx = SLOT_IDX_W'(b.seq % win);
          if (!st.slot_mark[sidx]) begin
            st.slot_mark[sidx] = 1'b1;
            has_reply = 1'b1;
          end
        end
        r.nack = 1'b0;
        r.seq = b.seq + 1'b1;
      end
      st.xor_acc = '0;
    end
    return has_reply;
  endfunction

  function automatic link_byte_t mk_byte(input logic [7:0] data, input logic start_f,
                                         input logic end_f, input logic [SEQ_BITS-1:0] seq,
                                         input logic [7:0] check);
    link_byte_t b;
    b.data = data;
    b.frame_start = start_f;
    b.frame_end = end_f;
    b.seq = seq;
    b.check = check;
    return b;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit throttle);
    int unsigned r;
    if (!throttle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // sequence numbers mostly in or near the receive window
  function automatic logic [SEQ_BITS-1:0] pick_seq();
    int unsigned         w, r;
    logic [SEQ_BITS-1:0] s;
    w = active_window(gen_state.window);
    r = $urandom_range(0, 99);
    s = gen_state.next_seq;
    if (r < 40) s = gen_state.next_seq;
    else if (r < 80)
      s = SEQ_BITS'(gen_state.next_seq + (w > 1 ? $urandom_range(1, w - 1) : 0));
    else if (r < 88) s = SEQ_BITS'(gen_state.next_seq - $urandom_range(1, 8));
    else if (r < 94) s = SEQ_BITS'(gen_state.next_seq + w + $urandom_range(0, 3));
    else s = rnd_seq();
    return s;
  endfunction

  task automatic push_byte(input link_byte_t b);
    reply_t ignored;
    link_bytes.insert(link_bytes.size(), b);
    void'(arq_reply_step(gen_state, b, ignored));
    phase_items++;
  endtask

  // one stuffed frame; corrupt spoils the check, esc_close escapes the closing byte,
  // merged puts start and end on the same byte
  task automatic queue_frame(input logic [SEQ_BITS-1:0] seq, input int body_len,
                             input bit corrupt, input bit esc_close, input bit merged);
    logic [7:0] acc, lit, tail, spoil;
    acc = '0;
    spoil = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
    if (merged) begin
      push_byte(mk_byte(rnd8(), 1'b1, 1'b1, seq, spoil));
    end else begin
      push_byte(mk_byte(rnd8(), 1'b1, 1'b0, rnd_seq(), rnd8()));
      for (int i = 0; i < body_len; i++) begin
        lit = rnd8();
        if ($urandom_range(0, 9) < 2) begin
          push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, rnd_seq(), rnd8()));
        end else if (lit == ESCAPE_BYTE) begin
          lit ^= 8'h01;
        end
        push_byte(mk_byte(lit, 1'b0, 1'b0, rnd_seq(), rnd8()));
        acc ^= lit;
      end
      tail = rnd8();
      if (esc_close) begin
        push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, rnd_seq(), rnd8()));
        acc ^= tail;
      end
      push_byte(mk_byte(tail, 1'b0, 1'b1, seq, acc ^ spoil));
    end
  endtask

  task automatic queue_random(input int target);
    int unsigned r;
    int          len;
    phase_items = 0;
    while (phase_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 86) begin
        len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 6) : $urandom_range(7, 20);
        queue_frame(pick_seq(), len, $urandom_range(0, 99) < 12, $urandom_range(0, 9) == 0,
                    len == 0 && $urandom_range(0, 4) == 0);
      end else if (r < 93) begin
        // stray bytes between frames still fold into the check
        repeat ($urandom_range(1, 3)) push_byte(mk_byte(rnd8(), 1'b0, 1'b0, rnd_seq(), rnd8()));
      end else if (r < 97) begin
        // abandoned frame, the next opening flag restarts it
        push_byte(mk_byte(rnd8(), 1'b1, 1'b0, rnd_seq(), rnd8()));
        repeat ($urandom_range(1, 4)) push_byte(mk_byte(rnd8(), 1'b0, 1'b0, rnd_seq(), rnd8()));
      end else begin
        // closing flag with no opening one
        push_byte(mk_byte(rnd8(), 1'b0, 1'b1, pick_seq(),
                          $urandom_range(0, 1) ? gen_state.xor_acc : rnd8()));
      end
    end
  endtask

  // window at reset is 4 and next number 0
  task automatic queue_directed();
    phase_items = 0;
    // empty frame, start and end on one byte: ack 1
    push_byte(mk_byte(8'h7E, 1'b1, 1'b1, 16'h0000, 8'h00));
    // out of order: seq 2 marks its slot
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h00, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'h0002, 8'hFF));
    // duplicate of a held slot: no reply
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'h0002, 8'h00));
    // escape right before the closing byte, in order: slides over slot 2
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b1, 16'h0001, ESCAPE_BYTE));
    // old frame dropped
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'h0000, 8'h00));
    // just past the window end dropped
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'h0007, 8'h00));
    // bad check: nack with the frame's own number
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h11, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'hFFFF, 8'h12));
    // escaped escape and escaped 0xff in the payload
    push_byte(mk_byte(8'h7E, 1'b1, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(ESCAPE_BYTE, 1'b0, 1'b1, 16'h0003, ESCAPE_BYTE ^ 8'hFF));
    // loose byte with no opening flag, then a closing flag
    push_byte(mk_byte(8'h5A, 1'b0, 1'b0, 16'h0000, 8'h00));
    push_byte(mk_byte(8'h7E, 1'b0, 1'b1, 16'h0004, 8'h5A));
  endtask

  // block idle: nothing queued or offered, every reply back, then the tail of a
  // frame end that made no reply
  task automatic wait_idle();
    do @(negedge clk);
    while (link_bytes.size() != 0 || s_axis_tvalid || pending_replies.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_wen <= 1'b0;
    rx_model.window = w;
    gen_state.window = w;
  endtask

  // link side: one byte held until its transfer, then an optional gap
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        n_bytes_in = n_bytes_in + 1;
        if (arq_reply_step(rx_model, on_wire, drv_reply))
          pending_replies.insert(pending_replies.size(), drv_reply);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (link_bytes.size() != 0) begin
        next_byte = link_bytes.pop_front();
        on_wire <= next_byte;
        s_axis_tdata <= {next_byte.check, next_byte.seq, next_byte.data};
        s_axis_tuser <= next_byte.frame_start;
        s_axis_tlast <= next_byte.frame_end;
        s_axis_tvalid <= 1'b1;
        send_gap <= pick_gap(send_throttle);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // reply side: check each reply transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          n_errors++;
          $display("%0t: reply with none expected, got nack=%0b seq=%h", $time, m_axis_tuser,
                   m_axis_tdata);
        end else begin
          want = pending_replies.pop_front();
          if (m_axis_tuser !== want.nack) begin
            n_errors++;
            $display("%0t: reply_is_nack expected %0b, got %0b", $time, want.nack, m_axis_tuser);
          end
          if (m_axis_tdata !== want.seq) begin
            n_errors++;
            $display("%0t: reply_seq expected %h, got %h", $time, want.seq, m_axis_tdata);
          end
          if (want.nack) n_nacks++;
          else n_acks++;
        end
      end
      // one long hold so the block backs up and stalls the link side
      if (!long_hold_done && n_bytes_in >= HOLD_AFTER) begin
        long_hold_done <= 1'b1;
        recv_wait <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_wait <= pick_gap(recv_throttle);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d replies outstanding", $time, quiet_cycles,
               pending_replies.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_model = '0;
    rx_model.window = WINDOW_RESET;
    gen_state = rx_model;
    rand_win_a = CFG_W'($urandom_range(2, 63));
    rand_win_b = CFG_W'($urandom_range(1, 64));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    wait_idle();
    write_window(7'd1);
    queue_random(100);
    wait_idle();
    write_window(7'd64);
    queue_random(160);
    wait_idle();
    // zero and over-range settings clamp to one and to the maximum
    write_window(7'd0);
    queue_random(70);
    wait_idle();
    write_window(7'd127);
    queue_random(70);
    wait_idle();
    send_throttle = 1'b0;
    recv_throttle = 1'b0;
    write_window(rand_win_a);
    queue_random(160);
    wait_idle();
    send_throttle = 1'b1;
    recv_throttle = 1'b1;
    write_window(rand_win_b);
    queue_random(160);
    wait_idle();

    $display("%0d link bytes in, %0d acks and %0d nacks checked, %0d mismatches", n_bytes_in,
             n_acks, n_nacks, n_errors);
    $display("windows 4, 1, 64, 0, 127, %0d, %0d; one reply hold of %0d cycles", rand_win_a,
             rand_win_b, LONG_HOLD);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
